[hw/rtl/format_string_integer_printer_core_assert.svh]
// Assertion macros used by the printer top level.
`ifndef FORMAT_STRING_INTEGER_PRINTER_CORE_ASSERT_SVH
`define FORMAT_STRING_INTEGER_PRINTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSIP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

[hw/rtl/fsip_pkg.sv]
// Types and constants of the format string integer printer.
package fsip_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int ARG_WIDTH   = 32;
   localparam int DEC_DIGITS  = 10;
   localparam int HEX_DIGITS  = ARG_WIDTH / 4;
   localparam int BCD_WIDTH   = 4 * DEC_DIGITS;
   localparam int DCNT_WIDTH  = $clog2(DEC_DIGITS + 1);
   localparam int BIT_CNT_WIDTH = $clog2(ARG_WIDTH);

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_D = 8'h64;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_C = 8'h63;

   localparam logic [CHAR_WIDTH-1:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef enum logic [0:0] {
      REQ_FMT = 1'b0,
      REQ_ARG = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_NORMAL  = 2'd0,
      PH_PERCENT = 2'd1,
      PH_AWAIT   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_D = 2'd0,
      OP_X = 2'd1,
      OP_C = 2'd2
   } op_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_CONV = 1'b1
   } state_type;

   // One output job for the character serialiser.
   typedef struct packed {
      logic                   head_vld;
      logic [CHAR_WIDTH-1:0]  head_char;
      logic                   tail_digits;
      logic [CHAR_WIDTH-1:0]  tail_char;
      logic [BCD_WIDTH-1:0]   digits;
      logic [DCNT_WIDTH-1:0]  dcnt;
   } ser_load_type;

endpackage

[hw/rtl/fsip_channels.sv]
// Handshake channel interfaces for the request and response streams.
interface fsip_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [fsip_pkg::CHAR_WIDTH-1:0]  fmt_char;
   logic [fsip_pkg::ARG_WIDTH-1:0]   arg_value;

   modport source (output valid, output req_type, output fmt_char, output arg_value,
                   input ready);
   modport sink   (input valid, input req_type, input fmt_char, input arg_value,
                   output ready);
endinterface

interface fsip_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fsip_pkg::CHAR_WIDTH-1:0]  out_char;
   logic                             last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[hw/rtl/fsip_bcd.sv]
// Bit-serial binary to BCD converter (shift and add three).
module fsip_bcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsip_pkg::ARG_WIDTH-1:0]  bin,
   output logic                            done,
   output logic [fsip_pkg::BCD_WIDTH-1:0]  bcd
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [fsip_pkg::BIT_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [fsip_pkg::ARG_WIDTH-1:0]      bin_ff, bin_in;
   logic [fsip_pkg::BCD_WIDTH-1:0]      bcd_ff, bcd_in;
   logic [fsip_pkg::BCD_WIDTH-1:0]      adj;

   // Each decimal digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < fsip_pkg::DEC_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = bin;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[fsip_pkg::BCD_WIDTH-2:0], bin_ff[fsip_pkg::ARG_WIDTH-1]};
         bin_in = {bin_ff[fsip_pkg::ARG_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fsip_pkg::BIT_CNT_WIDTH'(fsip_pkg::ARG_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

[hw/rtl/fsip_ser.sv]
// Character serialiser: emits an optional prefix and then a literal or a digit string.
module fsip_ser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  fsip_pkg::ser_load_type  job,
   output logic                    busy,
   fsip_rsp_if.source              rsp_chan
);

   logic                                  out_vld_ff, out_vld_in;
   logic [fsip_pkg::CHAR_WIDTH-1:0]       out_char_ff, out_char_in;
   logic                                  out_last_ff, out_last_in;
   logic                                  pend_ff, pend_in;
   logic                                  head_vld_ff, head_vld_in;
   logic [fsip_pkg::CHAR_WIDTH-1:0]       head_char_ff, head_char_in;
   logic                                  tail_digits_ff, tail_digits_in;
   logic [fsip_pkg::CHAR_WIDTH-1:0]       tail_char_ff, tail_char_in;
   logic [fsip_pkg::BCD_WIDTH-1:0]        digits_ff, digits_in;
   logic [fsip_pkg::DCNT_WIDTH-1:0]       dcnt_ff, dcnt_in;
   logic                                  started_ff, started_in;
   logic                                  out_free;
   logic [3:0]                            top_digit;

   assign out_free  = !out_vld_ff || rsp_chan.ready;
   assign top_digit = digits_ff[fsip_pkg::BCD_WIDTH-1 -: 4];

   always_comb begin
      out_vld_in     = out_vld_ff && !rsp_chan.ready;
      out_char_in    = out_char_ff;
      out_last_in    = out_last_ff;
      pend_in        = pend_ff;
      head_vld_in    = head_vld_ff;
      head_char_in   = head_char_ff;
      tail_digits_in = tail_digits_ff;
      tail_char_in   = tail_char_ff;
      digits_in      = digits_ff;
      dcnt_in        = dcnt_ff;
      started_in     = started_ff;
      if (load) begin
         pend_in        = 1'b1;
         head_vld_in    = job.head_vld;
         head_char_in   = job.head_char;
         tail_digits_in = job.tail_digits;
         tail_char_in   = job.tail_char;
         digits_in      = job.digits;
         dcnt_in        = job.dcnt;
         started_in     = 1'b0;
      end else if (pend_ff && out_free) begin
         if (head_vld_ff) begin
            out_vld_in  = 1'b1;
            out_char_in = head_char_ff;
            out_last_in = 1'b0;
            head_vld_in = 1'b0;
         end else if (!tail_digits_ff) begin
            out_vld_in  = 1'b1;
            out_char_in = tail_char_ff;
            out_last_in = 1'b1;
            pend_in     = 1'b0;
         end else begin
            digits_in = {digits_ff[fsip_pkg::BCD_WIDTH-5:0], 4'h0};
            dcnt_in   = dcnt_ff - 1'b1;
            // Leading zeros are dropped, but the final digit is always shown.
            if (top_digit != 4'h0 || started_ff || dcnt_ff == fsip_pkg::DCNT_WIDTH'(1)) begin
               out_vld_in  = 1'b1;
               out_char_in = fsip_pkg::DIGIT_CHARS[top_digit];
               out_last_in = (dcnt_ff == fsip_pkg::DCNT_WIDTH'(1));
               started_in  = 1'b1;
               pend_in     = (dcnt_ff != fsip_pkg::DCNT_WIDTH'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_ff     <= 1'b0;
         head_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_ff     <= pend_in;
         head_vld_ff <= head_vld_in;
      end
      out_char_ff    <= out_char_in;
      out_last_ff    <= out_last_in;
      head_char_ff   <= head_char_in;
      tail_digits_ff <= tail_digits_in;
      tail_char_ff   <= tail_char_in;
      digits_ff      <= digits_in;
      dcnt_ff        <= dcnt_in;
      started_ff     <= started_in;
   end

   assign busy               = pend_ff;
   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.out_char  = out_char_ff;
   assign rsp_chan.last_char = out_last_ff;

endmodule

[hw/rtl/format_string_integer_printer_core.sv]
// Top level of the format string printer for the d, x and c conversions.
//
// The block takes a stream of request transactions on req_chan: a format
// character (req_type 0) or a 32-bit argument word (req_type 1). It returns
// ASCII characters on rsp_chan, none, one or several per transaction, and
// marks the final character caused by a request with last_char. A plain
// character passes through the serialiser and then the output register. A c
// argument is shown in the same way; a hex argument also has its leading
// zero nibbles dropped. A decimal argument first passes through the
// bit-serial BCD converter, one argument bit per cycle over 32 conversion
// steps; the serialiser then emits a minus sign for a negative argument and
// the digits, with leading zeros dropped.
// The next request is taken as soon as the last character of the previous
// one has moved into the output register, so a stalled receiver holds back
// new requests only once that register and the serialiser are both full.
// Reset returns the parser to its normal phase and empties the output.
module format_string_integer_printer_core (
   input  logic        clock,
   input  logic        reset,
   fsip_req_if.sink    req_chan,
   fsip_rsp_if.source  rsp_chan
);

   `include "format_string_integer_printer_core_assert.svh"

   fsip_pkg::state_type                state_ff, state_in;
   fsip_pkg::phase_type                phase_ff, phase_in;
   fsip_pkg::op_type                   op_ff, op_in;
   logic                               neg_ff, neg_in;

   logic                               req_fire;
   logic                               ser_busy;
   logic                               ser_load_en;
   fsip_pkg::ser_load_type             ser_job;
   logic                               bcd_start;
   logic [fsip_pkg::ARG_WIDTH-1:0]     bcd_bin;
   logic                               bcd_done;
   logic [fsip_pkg::BCD_WIDTH-1:0]     bcd_value;
   logic                               arg_neg;
   logic [fsip_pkg::ARG_WIDTH-1:0]     arg_mag;

   // A new transaction is taken only when no conversion runs and the
   // serialiser has handed its last character to the output register.
   assign req_chan.ready = (state_ff == fsip_pkg::ST_IDLE) && !ser_busy;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Magnitude of a signed argument; the most negative value maps to itself,
   // which read as unsigned is exactly its magnitude.
   assign arg_neg = req_chan.arg_value[fsip_pkg::ARG_WIDTH-1];
   assign arg_mag = arg_neg ? (~req_chan.arg_value + 1'b1) : req_chan.arg_value;
   assign bcd_bin = arg_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsip_pkg::ST_IDLE;
         phase_ff <= fsip_pkg::PH_NORMAL;
         op_ff    <= fsip_pkg::OP_D;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         op_ff    <= op_in;
      end
      neg_ff <= neg_in;
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      op_in       = op_ff;
      neg_in      = neg_ff;
      ser_load_en = 1'b0;
      bcd_start   = 1'b0;
      ser_job     = '{head_vld: 1'b0, head_char: fsip_pkg::CHAR_PERCENT,
                      tail_digits: 1'b0, tail_char: req_chan.fmt_char,
                      digits: bcd_value, dcnt: fsip_pkg::DCNT_WIDTH'(fsip_pkg::DEC_DIGITS)};
      case (state_ff)
         fsip_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.req_type == fsip_pkg::REQ_ARG) begin
                  // An argument outside the awaiting phase is ignored.
                  if (phase_ff == fsip_pkg::PH_AWAIT) begin
                     phase_in = fsip_pkg::PH_NORMAL;
                     case (op_ff)
                        fsip_pkg::OP_D: begin
                           bcd_start = 1'b1;
                           neg_in    = arg_neg;
                           state_in  = fsip_pkg::ST_CONV;
                        end
                        fsip_pkg::OP_X: begin
                           ser_load_en         = 1'b1;
                           ser_job.tail_digits = 1'b1;
                           ser_job.digits      = {req_chan.arg_value,
                              (fsip_pkg::BCD_WIDTH - fsip_pkg::ARG_WIDTH)'(0)};
                           ser_job.dcnt = fsip_pkg::DCNT_WIDTH'(fsip_pkg::HEX_DIGITS);
                        end
                        default: begin
                           ser_load_en       = 1'b1;
                           ser_job.tail_char = req_chan.arg_value[fsip_pkg::CHAR_WIDTH-1:0];
                        end
                     endcase
                  end
               end else if (req_chan.fmt_char == fsip_pkg::CHAR_NUL) begin
                  // End of string: any trailing percent or pending conversion is dropped.
                  phase_in = fsip_pkg::PH_NORMAL;
               end else if (phase_ff == fsip_pkg::PH_PERCENT) begin
                  if (req_chan.fmt_char == fsip_pkg::CHAR_LOWER_D) begin
                     op_in    = fsip_pkg::OP_D;
                     phase_in = fsip_pkg::PH_AWAIT;
                  end else if (req_chan.fmt_char == fsip_pkg::CHAR_LOWER_X) begin
                     op_in    = fsip_pkg::OP_X;
                     phase_in = fsip_pkg::PH_AWAIT;
                  end else if (req_chan.fmt_char == fsip_pkg::CHAR_LOWER_C) begin
                     op_in    = fsip_pkg::OP_C;
                     phase_in = fsip_pkg::PH_AWAIT;
                  end else begin
                     // Unknown conversion: the percent sign and the character both pass.
                     phase_in         = fsip_pkg::PH_NORMAL;
                     ser_load_en      = 1'b1;
                     ser_job.head_vld = 1'b1;
                  end
               end else if (req_chan.fmt_char == fsip_pkg::CHAR_PERCENT) begin
                  phase_in = fsip_pkg::PH_PERCENT;
               end else begin
                  // Plain character; a pending conversion, if any, is abandoned.
                  phase_in    = fsip_pkg::PH_NORMAL;
                  ser_load_en = 1'b1;
               end
            end
         end
         fsip_pkg::ST_CONV: begin
            if (bcd_done) begin
               ser_load_en         = 1'b1;
               ser_job.head_vld    = neg_ff;
               ser_job.head_char   = fsip_pkg::CHAR_MINUS;
               ser_job.tail_digits = 1'b1;
               state_in            = fsip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsip_pkg::ST_IDLE;
         end
      endcase
   end

   fsip_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (bcd_bin),
      .done  (bcd_done),
      .bcd   (bcd_value)
   );

   fsip_ser u_ser (
      .clock    (clock),
      .reset    (reset),
      .load     (ser_load_en),
      .job      (ser_job),
      .busy     (ser_busy),
      .rsp_chan (rsp_chan)
   );

   // The converter only finishes while the controller waits for it.
   `FSIP_ASSERT_NOW(a_done_in_conv, clock, reset, bcd_done, state_ff == fsip_pkg::ST_CONV)
   // A job is never loaded over one that is still being serialised.
   `FSIP_ASSERT_NOW(a_load_when_free, clock, reset, ser_load_en, !ser_busy)
   // A loaded job keeps the serialiser busy in the following cycle.
   `FSIP_ASSERT_NEXT(a_load_busy, clock, reset, ser_load_en, ser_busy)
   // A character that is not the last one implies more characters are queued.
   `FSIP_ASSERT_NOW(a_more_pending, clock, reset, rsp_chan.valid && !rsp_chan.last_char,
                    ser_busy)

endmodule
